FILE: rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared constants, request codes and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int NUM_PORTS     = 16;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int AGE_W  = 8;
    localparam int CNT_W  = 9;
    localparam int REQ_W  = 2;

    localparam logic [AGE_W-1:0] AGE_TIMEOUT_RST = AGE_W'(30);
    localparam logic [AGE_W-1:0] AGE_MAX         = {AGE_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};

    // Stream payload layout.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_LEARN  = 2'd1,
        REQ_AGE    = 2'd2
    } t_req;

    // Request fields broadcast to every cell while one request is in flight.
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic              learn_ok;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_req_bus;

    // Token handed from cell to cell, one hop per cycle.
    typedef struct packed {
        logic              active;
        logic              found;
        logic [PORT_W-1:0] port;
        logic              free_vld;
        logic [IDX_W-1:0]  free_idx;
        logic [CNT_W-1:0]  aged;
    } t_token;

    // Insert of a new address into the lowest free slot.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_wr;

endpackage

FILE: rtl/mlt_cell.sv
// ----------------------------------------------------------------------------
// MAC learning table cell
// Holds one table entry and updates the token as it passes through.
// ----------------------------------------------------------------------------
module mlt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mlt_pkg::IDX_W-1:0]   i_idx,
    input  logic [mlt_pkg::AGE_W-1:0]   i_age_timeout,
    input  mlt_pkg::t_req_bus           i_req,
    input  mlt_pkg::t_wr                i_wr,
    input  mlt_pkg::t_token             i_tok,
    output mlt_pkg::t_token             o_tok
);

    logic                         r_valid, n_valid;
    logic [mlt_pkg::MAC_W-1:0]    r_mac, n_mac;
    logic [mlt_pkg::PORT_W-1:0]   r_port, n_port;
    logic [mlt_pkg::AGE_W-1:0]    r_age, n_age;
    mlt_pkg::t_token              r_tok, n_tok;

    logic                         w_match;
    logic [mlt_pkg::AGE_W-1:0]    w_age_inc;

    assign w_match   = r_valid && (r_mac == i_req.mac);
    assign w_age_inc = (r_age == mlt_pkg::AGE_MAX) ? r_age : r_age + 1'b1;

    always_comb begin
        n_valid = r_valid;
        n_mac   = r_mac;
        n_port  = r_port;
        n_age   = r_age;
        n_tok   = i_tok;
        if (i_tok.active) begin
            case (i_req.req)
                mlt_pkg::REQ_LOOKUP: begin
                    if (w_match && !i_tok.found) begin
                        n_tok.found = 1'b1;
                        n_tok.port  = r_port;
                    end
                end
                mlt_pkg::REQ_LEARN: begin
                    if (i_req.learn_ok) begin
                        if (w_match) begin
                            // Address already held: refresh in place.
                            n_tok.found = 1'b1;
                            n_port      = i_req.port;
                            n_age       = '0;
                        end else if (!r_valid && !i_tok.free_vld) begin
                            n_tok.free_vld = 1'b1;
                            n_tok.free_idx = i_idx;
                        end
                    end
                end
                mlt_pkg::REQ_AGE: begin
                    if (r_valid) begin
                        n_age = w_age_inc;
                        if (w_age_inc >= i_age_timeout) begin
                            n_valid = 1'b0;
                            if (i_tok.aged != mlt_pkg::COUNT_MAX) begin
                                n_tok.aged = i_tok.aged + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // The insert happens after the token has left the chain.
        if (i_wr.en && (i_wr.idx == i_idx)) begin
            n_valid = 1'b1;
            n_mac   = i_wr.mac;
            n_port  = i_wr.port;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mac  <= n_mac;
        r_port <= n_port;
        r_age  <= n_age;
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/mac_learning_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// MAC learning table with aging
//
// Channel   Direction  Handshake                        Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser: req_type
//                                                       tdata: mac_addr, port_in
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  hit, port_out, table_full,
//                                                       aged_count
// cfg       in         i_cfg_wr_en                      age_timeout
//
// One request is in flight at a time. A token walks the row of table cells,
// one cell per cycle: it is registered in r_launch, in each cell and in r_done,
// and the result then in the output register; the length of the cell row sets
// the delay. The next request is accepted once the result reaches the output
// register, while the result may still wait there, so requests never overlap.
// A stalled output holds the finished token at the end of the row. Reset
// empties the table at once and sets age_timeout to 30.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [1:0] req_type
    input  logic [mlt_pkg::REQ_W-1:0]         i_s_axis_tuser,
    // [47:0] mac_addr, [51:48] port_in
    input  logic [mlt_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] hit, [4:1] port_out, [5] table_full, [14:6] aged_count
    output logic [mlt_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [mlt_pkg::AGE_W-1:0]         i_cfg_wr_data
);

    logic                               r_busy, n_busy;
    logic                               r_launch;
    mlt_pkg::t_req_bus                  r_req;
    mlt_pkg::t_token                    r_done, n_done;
    logic                               r_out_vld, n_out_vld;
    logic [mlt_pkg::M_TDATA_W-1:0]      r_out_data, n_out_data;
    logic [mlt_pkg::AGE_W-1:0]          r_age_timeout;

    mlt_pkg::t_token                    w_tok [0:mlt_pkg::TABLE_ENTRIES];
    mlt_pkg::t_wr                       w_wr;
    logic                               w_accept;
    logic                               w_finish;
    logic                               w_hit;
    logic                               w_full;
    logic [mlt_pkg::PORT_W-1:0]         w_port_out;
    logic [mlt_pkg::CNT_W-1:0]          w_aged;

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;

    // Launch token enters the first cell the cycle after accept.
    assign w_tok[0] = {r_launch, {($bits(mlt_pkg::t_token) - 1){1'b0}}};

    for (genvar g = 0; g < mlt_pkg::TABLE_ENTRIES; g++) begin : g_cell
        mlt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_idx         (mlt_pkg::IDX_W'(g)),
            .i_age_timeout (r_age_timeout),
            .i_req         (r_req),
            .i_wr          (w_wr),
            .i_tok         (w_tok[g]),
            .o_tok         (w_tok[g+1])
        );
    end

    assign w_finish = r_done.active && (!r_out_vld || i_m_axis_tready);

    assign w_hit      = (r_req.req == mlt_pkg::REQ_LOOKUP) && r_done.found;
    assign w_port_out = w_hit ? r_done.port : '0;
    assign w_full     = (r_req.req == mlt_pkg::REQ_LEARN) && r_req.learn_ok
                        && !r_done.found && !r_done.free_vld;
    assign w_aged     = (r_req.req == mlt_pkg::REQ_AGE) ? r_done.aged : '0;

    always_comb begin
        w_wr      = '0;
        w_wr.en   = w_finish && (r_req.req == mlt_pkg::REQ_LEARN) && r_req.learn_ok
                    && !r_done.found && r_done.free_vld;
        w_wr.idx  = r_done.free_idx;
        w_wr.mac  = r_req.mac;
        w_wr.port = r_req.port;
    end

    always_comb begin
        n_busy     = r_busy;
        n_done     = r_done;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (w_tok[mlt_pkg::TABLE_ENTRIES].active) begin
            n_done = w_tok[mlt_pkg::TABLE_ENTRIES];
        end
        if (w_finish) begin
            n_done.active = 1'b0;
            n_busy        = 1'b0;
            n_out_vld     = 1'b1;
            n_out_data    = {1'b0, w_aged, w_full, w_port_out, w_hit};
        end
        if (w_accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_launch      <= 1'b0;
            r_done        <= '0;
            r_out_vld     <= 1'b0;
            r_age_timeout <= mlt_pkg::AGE_TIMEOUT_RST;
        end else begin
            r_busy    <= n_busy;
            r_launch  <= w_accept;
            r_done    <= n_done;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_age_timeout <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_accept) begin
            r_req.req      <= i_s_axis_tuser;
            r_req.mac      <= i_s_axis_tdata[47:0];
            r_req.port     <= i_s_axis_tdata[51:48];
            r_req.learn_ok <= (32'(i_s_axis_tdata[51:48]) < mlt_pkg::NUM_PORTS);
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/mlt_checker.sv
// ----------------------------------------------------------------------------
// MAC learning table port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module mlt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [mlt_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    // A pending result stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // Only one request walks the table at a time.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request accepted while one is in flight");

    // A port number is reported only with a hit.
    a_port_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[4:1] != '0) |-> o_m_axis_tdata[0])
        else $error("port_out set without hit");

    // Lookup, learn and tick results never mix.
    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[0] || o_m_axis_tdata[5])
        |-> (o_m_axis_tdata[14:6] == '0) && !(o_m_axis_tdata[0] && o_m_axis_tdata[5]))
        else $error("result fields of different request kinds both set");

endmodule

bind mac_learning_table_with_aging_top mlt_checker u_mlt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: sim/tb_mac_learning_table_with_aging_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MAC learning table with aging
// Drives lookup, learn, aging-tick and unknown-code requests with random bursts and gaps.
// It also stalls the result stream. Every result is checked against a local
// model of the forwarding table and its aging rules. The age timeout is
// changed between phases while the table is idle.
// ----------------------------------------------------------------------------
module tb_mac_learning_table_with_aging_top;

    localparam logic [mlt_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int POOL_SIZE   = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [mlt_pkg::REQ_W-1:0]  kind;
        logic [mlt_pkg::MAC_W-1:0]  mac;
        logic [mlt_pkg::PORT_W-1:0] port;
    } t_mac_req;

    typedef struct packed {
        logic                       hit;
        logic [mlt_pkg::PORT_W-1:0] port;
        logic                       full;
        logic [mlt_pkg::CNT_W-1:0]  aged;
    } t_fwd_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [mlt_pkg::REQ_W-1:0]     s_tuser = '0;
    logic [mlt_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          m_tready = 1'b0;
    logic [mlt_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic                          cfg_wr_en = 1'b0;
    logic [mlt_pkg::AGE_W-1:0]     cfg_wr_data = '0;

    mac_learning_table_with_aging_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    // Local copy of the forwarding table and its timeout.
    logic                       tbl_valid [mlt_pkg::TABLE_ENTRIES];
    logic [mlt_pkg::MAC_W-1:0]  tbl_mac   [mlt_pkg::TABLE_ENTRIES];
    logic [mlt_pkg::PORT_W-1:0] tbl_port  [mlt_pkg::TABLE_ENTRIES];
    logic [mlt_pkg::AGE_W-1:0]  tbl_age   [mlt_pkg::TABLE_ENTRIES];
    logic [mlt_pkg::AGE_W-1:0]  age_limit = mlt_pkg::AGE_TIMEOUT_RST;

    t_mac_req    pending_reqs[$];
    t_fwd_result expected_results[$];
    t_mac_req    cur_req = '0;
    logic        req_taken = 1'b0;
    logic        res_taken = 1'b0;
    int          tx_burst = 0;
    int          tx_gap = 0;
    int          rx_hold = 0;
    logic [15:0] rx_cyc = '0;
    int          mismatch_count = 0;
    int          result_count = 0;
    logic [mlt_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];
    logic [mlt_pkg::MAC_W-1:0] fill_macs [mlt_pkg::TABLE_ENTRIES];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_fwd_result apply_request(t_mac_req rq);
        t_fwd_result res;
        int slot;
        int i;
        res = '0;
        slot = -1;
        case (rq.kind)
            mlt_pkg::REQ_LOOKUP: begin
                for (i = 0; i < mlt_pkg::TABLE_ENTRIES && slot < 0; i++)
                    if (tbl_valid[i] && tbl_mac[i] == rq.mac) slot = i;
                if (slot >= 0) begin
                    res.hit  = 1'b1;
                    res.port = tbl_port[slot];
                end
            end
            mlt_pkg::REQ_LEARN: begin
                if (int'(rq.port) < mlt_pkg::NUM_PORTS) begin
                    for (i = 0; i < mlt_pkg::TABLE_ENTRIES && slot < 0; i++)
                        if (tbl_valid[i] && tbl_mac[i] == rq.mac) slot = i;
                    // A new address goes to the lowest free slot.
                    for (i = 0; i < mlt_pkg::TABLE_ENTRIES && slot < 0; i++)
                        if (!tbl_valid[i]) slot = i;
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b1;
                        tbl_mac[slot]   = rq.mac;
                        tbl_port[slot]  = rq.port;
                        tbl_age[slot]   = '0;
                    end else begin
                        res.full = 1'b1;
                    end
                end
            end
            mlt_pkg::REQ_AGE: begin
                for (i = 0; i < mlt_pkg::TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        if (tbl_age[i] < mlt_pkg::AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
                        if (tbl_age[i] >= age_limit) begin
                            tbl_valid[i] = 1'b0;
                            if (res.aged < mlt_pkg::COUNT_MAX) res.aged = res.aged + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Request sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (req_taken || !s_tvalid)) begin
            req_taken = 1'b0;
            if (tx_gap != 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.kind;
                s_tdata  <= {4'b0000, cur_req.port, cur_req.mac};
                if (tx_burst <= 1) begin
                    tx_burst = $urandom_range(1, 6);
                    tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    tx_burst--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: the stall pattern changes as the cycle counter rx_cyc advances.
    always @(negedge i_clk) begin
        rx_cyc = rx_cyc + 1'b1;
        case (rx_cyc[13:12])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_cyc[4:0] == 5'd0);
            default: begin
                // Long holds let the next request finish behind a waiting result.
                if (res_taken) rx_hold = $urandom_range(0, 400);
                if (rx_hold != 0) begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
        res_taken = 1'b0;
    end

    always @(posedge i_clk) begin
        t_fwd_result got;
        t_fwd_result want;
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                expected_results.push_back(apply_request(cur_req));
                req_taken = 1'b1;
            end
            if (o_m_axis_tvalid && m_tready) begin
                res_taken = 1'b1;
                result_count++;
                got.hit  = o_m_axis_tdata[0];
                got.port = o_m_axis_tdata[4:1];
                got.full = o_m_axis_tdata[5];
                got.aged = o_m_axis_tdata[14:6];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d arrived with no request outstanding: %h",
                                 result_count, o_m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.port !== want.port ||
                        got.full !== want.full || got.aged !== want.aged) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"result %0d: expected hit=%0d port=%0d full=%0d ",
                                      "aged=%0d, got hit=%0d port=%0d full=%0d aged=%0d"},
                                     result_count, want.hit, want.port, want.full,
                                     want.aged, got.hit, got.port, got.full, got.aged);
                    end
                end
            end
        end
    end

    task automatic queue_req(logic [mlt_pkg::REQ_W-1:0] kind,
                             logic [mlt_pkg::MAC_W-1:0] mac,
                             logic [mlt_pkg::PORT_W-1:0] port);
        t_mac_req rq;
        rq.kind = kind;
        rq.mac  = mac;
        rq.port = port;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        #1;
        while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // Writes the timeout only once no request is outstanding.
    task automatic set_timeout(logic [mlt_pkg::AGE_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        age_limit = value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [mlt_pkg::MAC_W-1:0] random_mac();
        return mlt_pkg::MAC_W'({$urandom(), $urandom()});
    endfunction

    task automatic queue_random_req();
        int pick;
        t_mac_req rq;
        pick    = $urandom_range(0, 99);
        rq.mac  = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        rq.port = mlt_pkg::PORT_W'($urandom_range(0, mlt_pkg::NUM_PORTS - 1));
        if (pick < 40) begin
            rq.kind = mlt_pkg::REQ_LEARN;
        end else if (pick < 75) begin
            rq.kind = mlt_pkg::REQ_LOOKUP;
            if (pick >= 71) rq.mac = random_mac();
        end else if (pick < 95) begin
            rq.kind = mlt_pkg::REQ_AGE;
        end else begin
            rq.kind = REQ_UNKNOWN;
            rq.mac  = random_mac();
        end
        pending_reqs.push_back(rq);
    endtask

    initial begin
        logic [mlt_pkg::AGE_W-1:0] phase_timeouts [5];
        logic [mlt_pkg::MAC_W-1:0] ones;
        logic [mlt_pkg::MAC_W-1:0] addr_a;
        int p;
        int k;

        for (k = 0; k < mlt_pkg::TABLE_ENTRIES; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_mac[k]   = '0;
            tbl_port[k]  = '0;
            tbl_age[k]   = '0;
        end
        ones   = '1;
        addr_a = random_mac();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, both address extremes, refresh, unknown request code.
        set_timeout(mlt_pkg::AGE_W'(30));
        queue_req(mlt_pkg::REQ_LOOKUP, '0, '0);
        queue_req(mlt_pkg::REQ_LOOKUP, ones, 4'hf);
        queue_req(mlt_pkg::REQ_LEARN, '0, 4'h0);
        queue_req(mlt_pkg::REQ_LEARN, ones, 4'hf);
        queue_req(mlt_pkg::REQ_LOOKUP, '0, 4'h5);
        queue_req(mlt_pkg::REQ_LOOKUP, ones, 4'h0);
        queue_req(mlt_pkg::REQ_LEARN, '0, 4'h9);
        queue_req(mlt_pkg::REQ_LOOKUP, '0, 4'ha);
        queue_req(REQ_UNKNOWN, ones, 4'hf);
        queue_req(mlt_pkg::REQ_AGE, ones, 4'hf);
        queue_req(mlt_pkg::REQ_LOOKUP, 48'h5555_5555_5555, 4'h0);

        // A timeout of one drops every entry on the first tick.
        set_timeout(mlt_pkg::AGE_W'(1));
        queue_req(mlt_pkg::REQ_AGE, '0, '0);
        queue_req(mlt_pkg::REQ_LOOKUP, '0, '0);

        // A zero timeout removes every entry on a tick, even a fresh one.
        set_timeout(mlt_pkg::AGE_W'(0));
        queue_req(mlt_pkg::REQ_AGE, addr_a, '0);
        queue_req(mlt_pkg::REQ_LEARN, addr_a, 4'h3);
        queue_req(mlt_pkg::REQ_AGE, addr_a, '0);

        // Relearning resets the age of an entry.
        set_timeout(mlt_pkg::AGE_W'(2));
        queue_req(mlt_pkg::REQ_LEARN, addr_a, 4'h7);
        queue_req(mlt_pkg::REQ_AGE, '0, '0);
        queue_req(mlt_pkg::REQ_LEARN, addr_a, 4'h8);
        queue_req(mlt_pkg::REQ_AGE, '0, '0);
        queue_req(mlt_pkg::REQ_LOOKUP, addr_a, '0);
        queue_req(mlt_pkg::REQ_AGE, '0, '0);

        // Fill every slot, overflow once, then age out the whole table.
        set_timeout(mlt_pkg::AGE_W'(255));
        for (k = 0; k < mlt_pkg::TABLE_ENTRIES; k++) begin
            fill_macs[k] = mlt_pkg::MAC_W'({random_mac() >> 8, 8'(k)});
            queue_req(mlt_pkg::REQ_LEARN, fill_macs[k],
                      mlt_pkg::PORT_W'($urandom_range(0, mlt_pkg::NUM_PORTS - 1)));
        end
        queue_req(mlt_pkg::REQ_LEARN, addr_a, 4'h2);
        queue_req(mlt_pkg::REQ_LEARN, fill_macs[100], 4'hc);
        queue_req(mlt_pkg::REQ_LOOKUP, fill_macs[100], '0);
        queue_req(mlt_pkg::REQ_LOOKUP, fill_macs[mlt_pkg::TABLE_ENTRIES - 1], '0);
        queue_req(mlt_pkg::REQ_LOOKUP, addr_a, '0);
        queue_req(mlt_pkg::REQ_AGE, '0, '0);
        set_timeout(mlt_pkg::AGE_W'(1));
        queue_req(mlt_pkg::REQ_AGE, '0, '0);

        // Random traffic over a small address pool so entries hit, refresh and age.
        phase_timeouts[0] = mlt_pkg::AGE_W'(3);
        phase_timeouts[1] = mlt_pkg::AGE_W'(6);
        phase_timeouts[2] = mlt_pkg::AGE_W'(255);
        phase_timeouts[3] = mlt_pkg::AGE_W'(1);
        phase_timeouts[4] = mlt_pkg::AGE_W'($urandom_range(2, 254));
        for (p = 0; p < 5; p++) begin
            set_timeout(phase_timeouts[p]);
            for (k = 0; k < POOL_SIZE; k++) mac_pool[k] = random_mac();
            repeat (115) queue_random_req();
        end

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/mlt_pkg.sv
rtl/mlt_cell.sv
rtl/mac_learning_table_with_aging_top.sv
rtl/mlt_checker.sv
sim/tb_mac_learning_table_with_aging_top.sv
